// ===== rtl/mm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm_pkg
// Shared constants, types and helpers of the matrix multiplier: sizes,
// register indexes, controller states and the command and status words
// between controller and datapath.
// ----------------------------------------------------------------------------
package mm_pkg;

    localparam int MAX_DIM     = 8;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int DIMV_W      = $clog2(MAX_DIM + 1);
    localparam int TOT_W       = $clog2(2 * STORE_DEPTH + 1);

    localparam int ELEM_W      = 32;
    localparam int MUL_W       = 2 * ELEM_W;
    localparam int PROD_W      = 52;
    localparam int FRAC_W      = 16;
    localparam int IDX_W       = 3;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INNER_A = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_B  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B  = CFG_IDX_W'(3);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_WAIT,
        ST_MAC,
        ST_DRAIN
    } mm_state_t;

    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] rd_a_addr;
        logic [ADDR_W-1:0] rd_b_addr;
        logic              issue;
        logic              first;
        logic              last;
        logic [DIM_W-1:0]  row;
        logic [DIM_W-1:0]  col;
        logic              last_result;
        logic              load_error;
    } mm_cmd_t;

    typedef struct packed {
        logic out_free;
        logic result_loaded;
    } mm_status_t;

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [DIMV_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [DIMV_W-1:0] r;
        if (v == '0)
        begin
            r = DIMV_W'(1);
        end
        else if (int'(v) > MAX_DIM)
        begin
            r = DIMV_W'(MAX_DIM);
        end
        else
        begin
            r = DIMV_W'(v);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/matrix_multiply.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply
// Dense matrix product of signed Q16.16 elements, 52-bit results with 16
// fraction bits.
// ----------------------------------------------------------------------------
// Load all of A then all of B row-major, one word per cycle while in_stall is
// low; the product then comes out row-major. Each product word is computed by
// the one shared multiplier, which walks the inner dimension one step a cycle,
// multiplying registered store reads.
// Input is held off while products are computed. When inner_a and rows_b
// differ, a single word with dimension_error and last_result set is given.
// A register write restarts the load with the first element of A.
module matrix_multiply
    import mm_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [ELEM_W-1:0]  element_value,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [PROD_W-1:0]       product_value,
    output logic [IDX_W-1:0]               out_row,
    output logic [IDX_W-1:0]               out_col,
    output logic                           dimension_error,
    output logic                           last_result,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data
);

    mm_cmd_t    dp_cmd;
    mm_status_t dp_status;

    mm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    mm_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (dp_cmd),
        .wr_data         (element_value),
        .status          (dp_status),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .product_value   (product_value),
        .out_row         (out_row),
        .out_col         (out_col),
        .dimension_error (dimension_error),
        .last_result     (last_result)
    );

    // error word carries no product
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dimension_error |->
            last_result && product_value == '0 && out_row == '0 && out_col == '0)
        else $error("error word with product fields set");

    // only one source loads the output register at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_status.result_loaded |-> !dp_cmd.load_error)
        else $error("product and error loaded together");

    // a finished product is shown on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_status.result_loaded |=> out_valid)
        else $error("finished product not shown");

    // no new multiply starts while the final word of a run is leaving
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_result |-> !dp_cmd.issue)
        else $error("multiply issued before run ended");

endmodule
`default_nettype wire

// ===== rtl/mm_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm_datapath
// Element stores, registered reads, one 32x32 multiplier stage, the
// accumulator and the output register.
// ----------------------------------------------------------------------------
module mm_datapath
    import mm_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire mm_cmd_t                   cmd,
    input  wire logic signed [ELEM_W-1:0]  wr_data,
    output mm_status_t                     status,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [PROD_W-1:0]       product_value,
    output logic [IDX_W-1:0]               out_row,
    output logic [IDX_W-1:0]               out_col,
    output logic                           dimension_error,
    output logic                           last_result
);

    logic signed [ELEM_W-1:0] store_a [STORE_DEPTH];
    logic signed [ELEM_W-1:0] store_b [STORE_DEPTH];

    logic signed [ELEM_W-1:0] rd_a_reg;
    logic signed [ELEM_W-1:0] rd_b_reg;
    logic signed [MUL_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] acc_next;
    logic signed [PROD_W-1:0] acc_sum;
    logic signed [MUL_W-1:0]  prod_shift;
    logic signed [PROD_W-1:0] prod_term;

    logic s1_valid_reg, s1_first_reg, s1_last_reg;
    logic s2_valid_reg, s2_first_reg, s2_last_reg;

    logic                     out_valid_reg, out_valid_next;
    logic signed [PROD_W-1:0] product_reg;
    logic [IDX_W-1:0]         row_reg;
    logic [IDX_W-1:0]         col_reg;
    logic                     err_reg;
    logic                     last_reg;

    logic out_free;
    logic result_loaded;

    // stores and pipeline payload
    always_ff @(posedge clk)
    begin
        if (cmd.wr_a)
        begin
            store_a[cmd.wr_addr] <= wr_data;
        end
        if (cmd.wr_b)
        begin
            store_b[cmd.wr_addr] <= wr_data;
        end
        rd_a_reg <= store_a[cmd.rd_a_addr];
        rd_b_reg <= store_b[cmd.rd_b_addr];
        prod_reg <= rd_a_reg * rd_b_reg;
        acc_reg  <= acc_next;
    end

    // arithmetic shift keeps floor rounding
    assign prod_shift = prod_reg >>> FRAC_W;
    assign prod_term  = PROD_W'(prod_shift);
    assign acc_sum    = (s2_first_reg ? PROD_W'(0) : acc_reg) + prod_term;
    assign acc_next   = s2_valid_reg ? acc_sum : acc_reg;

    assign result_loaded = s2_valid_reg && s2_last_reg;
    assign out_free      = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (result_loaded || cmd.load_error)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_first_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_first_reg  <= 1'b0;
            s2_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= cmd.issue;
            s1_first_reg  <= cmd.first;
            s1_last_reg   <= cmd.last;
            s2_valid_reg  <= s1_valid_reg;
            s2_first_reg  <= s1_first_reg;
            s2_last_reg   <= s1_last_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (result_loaded)
        begin
            product_reg <= acc_sum;
            row_reg     <= IDX_W'(cmd.row);
            col_reg     <= IDX_W'(cmd.col);
            err_reg     <= 1'b0;
            last_reg    <= cmd.last_result;
        end
        else if (cmd.load_error)
        begin
            product_reg <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            err_reg     <= 1'b1;
            last_reg    <= 1'b1;
        end
    end

    assign status.out_free      = out_free;
    assign status.result_loaded = result_loaded;

    assign out_valid       = out_valid_reg;
    assign product_value   = product_reg;
    assign out_row         = row_reg;
    assign out_col         = col_reg;
    assign dimension_error = err_reg;
    assign last_result     = last_reg;

endmodule
`default_nettype wire

// ===== rtl/mm_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm_ctrl
// Configuration registers, load counter and the sequencer that walks the
// product matrix row by row and the inner dimension one step a cycle.
// ----------------------------------------------------------------------------
module mm_ctrl
    import mm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire mm_status_t           status,
    output mm_cmd_t                   cmd
);

    mm_state_t state_reg, state_next;

    logic [CFG_W-1:0]  rows_a_reg, inner_a_reg, rows_b_reg, cols_b_reg;
    logic [TOT_W-1:0]  load_count_reg, load_count_next;
    logic [DIM_W-1:0]  i_reg, i_next;
    logic [DIM_W-1:0]  j_reg, j_next;
    logic [DIM_W-1:0]  k_reg, k_next;
    logic [ADDR_W-1:0] a_base_reg, a_base_next;
    logic [ADDR_W-1:0] a_addr_reg, a_addr_next;
    logic [ADDR_W-1:0] b_addr_reg, b_addr_next;

    logic [DIMV_W-1:0] ra, ia, rb, cb;
    logic [TOT_W-1:0]  na, total, cnt;
    logic              cfg_fire, cfg_hit, in_fire, is_a, final_elem;
    logic              mismatch, i_last, j_last, k_last;

    assign ra = eff_dim(rows_a_reg);
    assign ia = eff_dim(inner_a_reg);
    assign rb = eff_dim(rows_b_reg);
    assign cb = eff_dim(cols_b_reg);

    assign na    = TOT_W'(ra) * TOT_W'(ia);
    assign total = na + TOT_W'(rb) * TOT_W'(cb);
    assign cnt   = (load_count_reg >= total) ? '0 : load_count_reg;

    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign cfg_hit    = cfg_fire && (cfg_index == REG_ROWS_A || cfg_index == REG_INNER_A
                        || cfg_index == REG_ROWS_B || cfg_index == REG_COLS_B);
    assign in_fire    = in_valid && (state_reg == ST_LOAD);
    assign is_a       = cnt < na;
    assign final_elem = (cnt + TOT_W'(1)) == total;

    assign mismatch = ia != rb;
    assign i_last   = DIMV_W'(i_reg) == (ra - DIMV_W'(1));
    assign j_last   = DIMV_W'(j_reg) == (cb - DIMV_W'(1));
    assign k_last   = DIMV_W'(k_reg) == (ia - DIMV_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && final_elem)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (status.out_free)
                begin
                    state_next = mismatch ? ST_LOAD : ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.result_loaded)
                begin
                    state_next = (i_last && j_last) ? ST_LOAD : ST_WAIT;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall        = 1'b1;
        cmd.wr_a        = 1'b0;
        cmd.wr_b        = 1'b0;
        cmd.wr_addr     = is_a ? ADDR_W'(cnt) : ADDR_W'(cnt - na);
        cmd.rd_a_addr   = a_addr_reg;
        cmd.rd_b_addr   = b_addr_reg;
        cmd.issue       = 1'b0;
        cmd.first       = k_reg == '0;
        cmd.last        = k_last;
        cmd.row         = i_reg;
        cmd.col         = j_reg;
        cmd.last_result = i_last && j_last;
        cmd.load_error  = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_stall = 1'b0;
                cmd.wr_a = in_fire && is_a;
                cmd.wr_b = in_fire && !is_a;
            end
            ST_WAIT:
            begin
                cmd.load_error = status.out_free && mismatch;
            end
            ST_MAC:
            begin
                cmd.issue = 1'b1;
            end
            ST_DRAIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // counters and addresses
    always_comb
    begin
        load_count_next = load_count_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        a_base_next     = a_base_reg;
        a_addr_next     = a_addr_reg;
        b_addr_next     = b_addr_reg;

        if (cfg_hit)
        begin
            load_count_next = '0;
        end
        else if (in_fire)
        begin
            load_count_next = final_elem ? '0 : cnt + TOT_W'(1);
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && final_elem)
                begin
                    i_next      = '0;
                    j_next      = '0;
                    a_base_next = '0;
                end
            end
            ST_WAIT:
            begin
                a_addr_next = a_base_reg;
                b_addr_next = ADDR_W'(j_reg);
                k_next      = '0;
            end
            ST_MAC:
            begin
                a_addr_next = a_addr_reg + ADDR_W'(1);
                b_addr_next = b_addr_reg + ADDR_W'(cb);
                k_next      = k_reg + DIM_W'(1);
            end
            ST_DRAIN:
            begin
                if (status.result_loaded)
                begin
                    if (j_last)
                    begin
                        j_next = '0;
                        if (!i_last)
                        begin
                            i_next      = i_reg + DIM_W'(1);
                            a_base_next = a_base_reg + ADDR_W'(ia);
                        end
                    end
                    else
                    begin
                        j_next = j_reg + DIM_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            rows_a_reg     <= CFG_W'(MAX_DIM);
            inner_a_reg    <= CFG_W'(MAX_DIM);
            rows_b_reg     <= CFG_W'(MAX_DIM);
            cols_b_reg     <= CFG_W'(MAX_DIM);
            load_count_reg <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            a_base_reg     <= '0;
            a_addr_reg     <= '0;
            b_addr_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            a_base_reg     <= a_base_next;
            a_addr_reg     <= a_addr_next;
            b_addr_reg     <= b_addr_next;
            if (cfg_fire)
            begin
                unique case (cfg_index)
                    REG_ROWS_A:  rows_a_reg  <= cfg_data;
                    REG_INNER_A: inner_a_reg <= cfg_data;
                    REG_ROWS_B:  rows_b_reg  <= cfg_data;
                    REG_COLS_B:  cols_b_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire
